/* src/klte_pkg.sv */
// Shared constants, types and control structs for the LRU key table.
package klte_pkg;

   localparam int ENTRIES   = 16;
   localparam int KEY_BITS  = 32;
   localparam int IDX_BITS  = $clog2(ENTRIES);
   localparam int FILL_BITS = $clog2(ENTRIES + 1);
   localparam int TIME_BITS = 48;

   typedef logic [IDX_BITS-1:0]  idx_type;
   typedef logic [FILL_BITS-1:0] fill_type;
   typedef logic [KEY_BITS-1:0]  key_type;
   typedef logic [TIME_BITS-1:0] time_type;

   typedef enum logic [1:0] {
      OUT_IGNORED  = 2'd0,
      OUT_SEEN     = 2'd1,
      OUT_ADDED    = 2'd2,
      OUT_REPLACED = 2'd3
   } outcome_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic start;   // capture the accepted request and reset the scan
      logic issue;   // read the next table entry
      logic commit;  // update the table and load the response register
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic skip_scan;   // empty key or empty table: nothing to scan
      logic last_issue;  // the entry read now is the last filled one
   } status_type;

endpackage

/* src/klte_ctrl.sv */
// Controller state machine that sequences the table scan and the response.
module klte_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  klte_pkg::status_type status,
   output klte_pkg::cmd_type    cmd
);
   import klte_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_DRAIN,
      ST_COMMIT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_free;

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in   = state_ff;
      cmd.start  = 1'b0;
      cmd.issue  = 1'b0;
      cmd.commit = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            if (status.skip_scan) begin
               state_in = ST_COMMIT;
            end else begin
               cmd.issue = 1'b1;
               if (status.last_issue) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (rsp_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTHESIS
   a_commit_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_valid_ff || rsp_ready))
      else $error("response register overwritten while still pending");

   a_rsp_from_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.commit))
      else $error("response became valid without a commit");

   a_no_issue_on_skip: assert property (@(posedge clock) disable iff (reset)
      cmd.issue |-> !status.skip_scan)
      else $error("table read issued for a request that needs no scan");
`endif

endmodule

/* src/klte_dpath.sv */
// Datapath: key/time table memories, scan compare, eviction choice and response.
module klte_dpath (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [31:0]            req_name_key,
   input  logic                   req_name_empty,
   input  logic [47:0]            req_now_ms,
   input  klte_pkg::cmd_type      cmd,
   output klte_pkg::status_type   status,
   output logic [1:0]             rsp_outcome,
   output logic [3:0]             rsp_slot_index,
   output logic [4:0]             rsp_occupied_count
);
   import klte_pkg::*;

   key_type  key_mem_ff  [ENTRIES];
   time_type time_mem_ff [ENTRIES];

   key_type  key_ff;
   logic     empty_ff;
   time_type now_ff;

   fill_type fill_ff, fill_in;
   idx_type  issue_idx_ff;
   logic     cmp_valid_ff;
   idx_type  cmp_idx_ff;
   key_type  rd_key_ff;
   time_type rd_time_ff;

   logic     hit_ff, hit_in;
   idx_type  hit_slot_ff, hit_slot_in;
   time_type min_time_ff, min_time_in;
   idx_type  min_slot_ff, min_slot_in;

   outcome_type outcome_sel;
   idx_type     slot_sel;
   logic        wr_time, wr_key;

   logic [1:0] rsp_outcome_ff;
   logic [3:0] rsp_slot_ff;
   logic [4:0] rsp_count_ff;

   assign status.skip_scan  = empty_ff || (fill_ff == '0);
   assign status.last_issue = (FILL_BITS'(issue_idx_ff) + FILL_BITS'(1)) == fill_ff;

   // Running search: first matching key, and oldest time with lowest index on ties.
   always_comb begin
      hit_in      = hit_ff;
      hit_slot_in = hit_slot_ff;
      min_time_in = min_time_ff;
      min_slot_in = min_slot_ff;
      if (cmd.start) begin
         hit_in = 1'b0;
      end else if (cmp_valid_ff) begin
         if (!hit_ff && (rd_key_ff == key_ff)) begin
            hit_in      = 1'b1;
            hit_slot_in = cmp_idx_ff;
         end
         if ((cmp_idx_ff == '0) || (rd_time_ff < min_time_ff)) begin
            min_time_in = rd_time_ff;
            min_slot_in = cmp_idx_ff;
         end
      end
   end

   always_comb begin
      outcome_sel = OUT_IGNORED;
      slot_sel    = '0;
      wr_time     = 1'b0;
      wr_key      = 1'b0;
      fill_in     = fill_ff;
      if (cmd.commit && !empty_ff) begin
         wr_time = 1'b1;
         priority if (hit_ff) begin
            outcome_sel = OUT_SEEN;
            slot_sel    = hit_slot_ff;
         end else if (fill_ff < FILL_BITS'(ENTRIES)) begin
            outcome_sel = OUT_ADDED;
            slot_sel    = IDX_BITS'(fill_ff);
            wr_key      = 1'b1;
            fill_in     = fill_ff + FILL_BITS'(1);
         end else begin
            outcome_sel = OUT_REPLACED;
            slot_sel    = min_slot_ff;
            wr_key      = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         cmp_valid_ff <= 1'b0;
         hit_ff       <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         cmp_valid_ff <= cmd.issue;
         hit_ff       <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         key_ff       <= KEY_BITS'(req_name_key);
         empty_ff     <= req_name_empty;
         now_ff       <= req_now_ms;
         issue_idx_ff <= '0;
      end else if (cmd.issue) begin
         issue_idx_ff <= issue_idx_ff + IDX_BITS'(1);
      end
      if (cmd.issue) begin
         cmp_idx_ff <= issue_idx_ff;
      end
      hit_slot_ff <= hit_slot_in;
      min_time_ff <= min_time_in;
      min_slot_ff <= min_slot_in;
      if (cmd.commit) begin
         rsp_outcome_ff <= outcome_sel;
         rsp_slot_ff    <= 4'(slot_sel);
         rsp_count_ff   <= 5'(fill_in);
      end
   end

   // Table memories: one read port for the scan, one write port for the commit.
   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         rd_key_ff  <= key_mem_ff[issue_idx_ff];
         rd_time_ff <= time_mem_ff[issue_idx_ff];
      end
      if (wr_key) begin
         key_mem_ff[slot_sel] <= key_ff;
      end
      if (wr_time) begin
         time_mem_ff[slot_sel] <= now_ff;
      end
   end

   assign rsp_outcome        = rsp_outcome_ff;
   assign rsp_slot_index     = rsp_slot_ff;
   assign rsp_occupied_count = rsp_count_ff;

`ifndef SYNTHESIS
   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_BITS'(ENTRIES))
      else $error("fill count exceeds table size");

   a_hit_in_range: assert property (@(posedge clock) disable iff (reset)
      hit_ff |-> (FILL_BITS'(hit_slot_ff) < fill_ff))
      else $error("matched slot lies beyond the filled part of the table");

   a_commit_after_drain: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> !cmp_valid_ff)
      else $error("commit while a table compare is still outstanding");
`endif

endmodule

/* src/keyed_table_lru_timestamp_evict.sv */
// Top level of the LRU key table: a controller and a datapath joined by command and status.
// An accepted request is scanned one table entry per cycle up to the table fill (0 to 16);
// an empty key or an empty table skips the scan. A held response delays the commit.
// Requests are taken one at a time, in IDLE only; the scan runs over the single read port
// of the key and timestamp memories.
// Reset clears the fill count and all control state; table contents stay undefined.
module keyed_table_lru_timestamp_evict (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_name_key,
   input  logic        req_name_empty,
   input  logic [47:0] req_now_ms,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_outcome,
   output logic [3:0]  rsp_slot_index,
   output logic [4:0]  rsp_occupied_count
);
   import klte_pkg::*;

   // The controller walks IDLE, ISSUE, DRAIN and COMMIT. In ISSUE it reads one table
   // entry per cycle up to the current fill; DRAIN lets the last read data be compared.
   cmd_type    cmd;
   status_type status;

   klte_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds the request, the memories, the running match and oldest-entry
   // search, and the response register. The response register lets a new request be
   // taken while the previous response still waits for the consumer.
   klte_dpath u_dpath (
      .clock              (clock),
      .reset              (reset),
      .req_name_key       (req_name_key),
      .req_name_empty     (req_name_empty),
      .req_now_ms         (req_now_ms),
      .cmd                (cmd),
      .status             (status),
      .rsp_outcome        (rsp_outcome),
      .rsp_slot_index     (rsp_slot_index),
      .rsp_occupied_count (rsp_occupied_count)
   );

endmodule
